@@ hdl/md5_stream_hash_assert.svh @@
// Assertion macros shared by the MD5 stream hash controller and datapath.
// Needs nothing else; bodies vanish when SYNTHESIS is defined.
`ifndef MD5_STREAM_HASH_ASSERT_SVH
`define MD5_STREAM_HASH_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset
`define MD5_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("md5 assertion failed");
// Next-cycle implication
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("md5 assertion failed");
`else
`define MD5_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/md5_pkg.sv @@
`timescale 1ns / 1ps
// Types, constants and round tables for the MD5 stream hash.
// Used by md5_ctrl, md5_dp and md5_stream_hash; depends on nothing.
package md5_pkg;

   // Chaining word values at the start of every message
   localparam logic [31:0] CHAIN_INIT_A = 32'h67452301;
   localparam logic [31:0] CHAIN_INIT_B = 32'hefcdab89;
   localparam logic [31:0] CHAIN_INIT_C = 32'h98badcfe;
   localparam logic [31:0] CHAIN_INIT_D = 32'h10325476;

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS       = 6'd56;
   localparam logic [5:0] LAST_POS      = 6'h3F;
   localparam logic [5:0] LAST_ROUND    = 6'd63;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   // Source of a byte written into the block buffer
   typedef enum logic [1:0] {
      BSEL_INPUT,
      BSEL_MARK,
      BSEL_ZERO,
      BSEL_LENGTH
   } byte_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic         byte_we;
      logic [5:0]   byte_addr;
      byte_sel_type byte_sel;
      logic         count_inc;
      logic         load_work;
      logic         round_en;
      logic [5:0]   round_idx;
      logic [5:0]   kw_idx;
      logic         chain_add;
      logic         emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [5:0] fill_pos;
      logic       out_free;
   } stat_type;

   // Message word used by a round
   function automatic logic [3:0] msg_index(input logic [5:0] idx);
      logic [3:0] i;
      logic [3:0] g;
      i = idx[3:0];
      case (idx[5:4])
         2'd0:    g = i;
         2'd1:    g = 4'd5 * i + 4'd1;
         2'd2:    g = 4'd3 * i + 4'd5;
         default: g = 4'd7 * i;
      endcase
      return g;
   endfunction

   // Left rotation amount of a round
   function automatic logic [4:0] round_shift(input logic [5:0] idx);
      logic [4:0] s;
      case ({idx[5:4], idx[1:0]})
         4'h0:    s = 5'd7;
         4'h1:    s = 5'd12;
         4'h2:    s = 5'd17;
         4'h3:    s = 5'd22;
         4'h4:    s = 5'd5;
         4'h5:    s = 5'd9;
         4'h6:    s = 5'd14;
         4'h7:    s = 5'd20;
         4'h8:    s = 5'd4;
         4'h9:    s = 5'd11;
         4'hA:    s = 5'd16;
         4'hB:    s = 5'd23;
         4'hC:    s = 5'd6;
         4'hD:    s = 5'd10;
         4'hE:    s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

   // Additive round constant
   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:    k = 32'hd76aa478;
         6'd1:    k = 32'he8c7b756;
         6'd2:    k = 32'h242070db;
         6'd3:    k = 32'hc1bdceee;
         6'd4:    k = 32'hf57c0faf;
         6'd5:    k = 32'h4787c62a;
         6'd6:    k = 32'ha8304613;
         6'd7:    k = 32'hfd469501;
         6'd8:    k = 32'h698098d8;
         6'd9:    k = 32'h8b44f7af;
         6'd10:   k = 32'hffff5bb1;
         6'd11:   k = 32'h895cd7be;
         6'd12:   k = 32'h6b901122;
         6'd13:   k = 32'hfd987193;
         6'd14:   k = 32'ha679438e;
         6'd15:   k = 32'h49b40821;
         6'd16:   k = 32'hf61e2562;
         6'd17:   k = 32'hc040b340;
         6'd18:   k = 32'h265e5a51;
         6'd19:   k = 32'he9b6c7aa;
         6'd20:   k = 32'hd62f105d;
         6'd21:   k = 32'h02441453;
         6'd22:   k = 32'hd8a1e681;
         6'd23:   k = 32'he7d3fbc8;
         6'd24:   k = 32'h21e1cde6;
         6'd25:   k = 32'hc33707d6;
         6'd26:   k = 32'hf4d50d87;
         6'd27:   k = 32'h455a14ed;
         6'd28:   k = 32'ha9e3e905;
         6'd29:   k = 32'hfcefa3f8;
         6'd30:   k = 32'h676f02d9;
         6'd31:   k = 32'h8d2a4c8a;
         6'd32:   k = 32'hfffa3942;
         6'd33:   k = 32'h8771f681;
         6'd34:   k = 32'h6d9d6122;
         6'd35:   k = 32'hfde5380c;
         6'd36:   k = 32'ha4beea44;
         6'd37:   k = 32'h4bdecfa9;
         6'd38:   k = 32'hf6bb4b60;
         6'd39:   k = 32'hbebfbc70;
         6'd40:   k = 32'h289b7ec6;
         6'd41:   k = 32'heaa127fa;
         6'd42:   k = 32'hd4ef3085;
         6'd43:   k = 32'h04881d05;
         6'd44:   k = 32'hd9d4d039;
         6'd45:   k = 32'he6db99e5;
         6'd46:   k = 32'h1fa27cf8;
         6'd47:   k = 32'hc4ac5665;
         6'd48:   k = 32'hf4292244;
         6'd49:   k = 32'h432aff97;
         6'd50:   k = 32'hab9423a7;
         6'd51:   k = 32'hfc93a039;
         6'd52:   k = 32'h655b59c3;
         6'd53:   k = 32'h8f0ccc92;
         6'd54:   k = 32'hffeff47d;
         6'd55:   k = 32'h85845dd1;
         6'd56:   k = 32'h6fa87e4f;
         6'd57:   k = 32'hfe2ce6e0;
         6'd58:   k = 32'ha3014314;
         6'd59:   k = 32'h4e0811a1;
         6'd60:   k = 32'hf7537e82;
         6'd61:   k = 32'hbd3af235;
         6'd62:   k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

endpackage

@@ hdl/md5_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing controller of the MD5 stream hash: absorb, pad, compress, emit.
// Depends on md5_pkg and md5_stream_hash_assert.svh.
`include "md5_stream_hash_assert.svh"
module md5_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_byte_valid,
   input  logic              req_last,
   input  md5_pkg::stat_type stat,
   output md5_pkg::cmd_type  cmd
);

   md5_pkg::state_type state_ff, state_in;
   md5_pkg::state_type ret_ff, ret_in;
   logic [5:0]         pp_ff, pp_in;
   logic [5:0]         rnd_ff, rnd_in;
   logic               accept;

   assign req_tready = (state_ff == md5_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Next state, return point, pad position and round count
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      pp_in    = pp_ff;
      rnd_in   = rnd_ff;
      case (state_ff)
         md5_pkg::ST_IDLE: begin
            if (accept) begin
               pp_in = stat.fill_pos + {5'd0, req_byte_valid};
               if (req_byte_valid && stat.fill_pos == md5_pkg::LAST_POS) begin
                  state_in = md5_pkg::ST_LOAD;
                  ret_in   = req_last ? md5_pkg::ST_PAD_MARK : md5_pkg::ST_IDLE;
               end else if (req_last) begin
                  state_in = md5_pkg::ST_PAD_MARK;
               end
            end
         end
         md5_pkg::ST_PAD_MARK: begin
            pp_in = pp_ff + 6'd1;
            if (pp_ff == md5_pkg::LAST_POS) begin
               state_in = md5_pkg::ST_LOAD;
               ret_in   = md5_pkg::ST_PAD_ZERO;
            end else begin
               state_in = md5_pkg::ST_PAD_ZERO;
            end
         end
         md5_pkg::ST_PAD_ZERO: begin
            if (pp_ff == md5_pkg::LEN_POS) begin
               state_in = md5_pkg::ST_PAD_LEN;
            end else begin
               pp_in = pp_ff + 6'd1;
               if (pp_ff == md5_pkg::LAST_POS) begin
                  state_in = md5_pkg::ST_LOAD;
                  ret_in   = md5_pkg::ST_PAD_ZERO;
               end
            end
         end
         md5_pkg::ST_PAD_LEN: begin
            pp_in = pp_ff + 6'd1;
            if (pp_ff == md5_pkg::LAST_POS) begin
               state_in = md5_pkg::ST_LOAD;
               ret_in   = md5_pkg::ST_EMIT;
            end
         end
         md5_pkg::ST_LOAD: begin
            rnd_in   = 6'd0;
            state_in = md5_pkg::ST_ROUND;
         end
         md5_pkg::ST_ROUND: begin
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == md5_pkg::LAST_ROUND) begin
               state_in = md5_pkg::ST_ADD;
            end
         end
         md5_pkg::ST_ADD: begin
            state_in = ret_ff;
         end
         md5_pkg::ST_EMIT: begin
            if (stat.out_free) begin
               state_in = md5_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = md5_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd           = '0;
      cmd.byte_sel  = md5_pkg::BSEL_INPUT;
      cmd.byte_addr = pp_ff;
      cmd.round_idx = rnd_ff;
      cmd.kw_idx    = rnd_ff + 6'd1;
      case (state_ff)
         md5_pkg::ST_IDLE: begin
            cmd.byte_addr = stat.fill_pos;
            cmd.byte_we   = accept && req_byte_valid;
            cmd.count_inc = accept && req_byte_valid;
         end
         md5_pkg::ST_PAD_MARK: begin
            cmd.byte_we  = 1'b1;
            cmd.byte_sel = md5_pkg::BSEL_MARK;
         end
         md5_pkg::ST_PAD_ZERO: begin
            cmd.byte_we  = (pp_ff != md5_pkg::LEN_POS);
            cmd.byte_sel = md5_pkg::BSEL_ZERO;
         end
         md5_pkg::ST_PAD_LEN: begin
            cmd.byte_we  = 1'b1;
            cmd.byte_sel = md5_pkg::BSEL_LENGTH;
         end
         md5_pkg::ST_LOAD: begin
            cmd.load_work = 1'b1;
            cmd.kw_idx    = 6'd0;
         end
         md5_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
         end
         md5_pkg::ST_ADD: begin
            cmd.chain_add = 1'b1;
         end
         md5_pkg::ST_EMIT: begin
            cmd.emit = stat.out_free;
         end
         default: begin
            cmd.byte_we = 1'b0;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= md5_pkg::ST_IDLE;
         ret_ff   <= md5_pkg::ST_IDLE;
         pp_ff    <= 6'd0;
         rnd_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         pp_ff    <= pp_in;
         rnd_ff   <= rnd_in;
      end
   end

   `MD5_ASSERT_NEXT(a_load_starts_round0, clock, reset, cmd.load_work, cmd.round_en && cmd.round_idx == 6'd0)
   `MD5_ASSERT_IMPLIES(a_emit_needs_free, clock, reset, cmd.emit, stat.out_free)
   `MD5_ASSERT_IMPLIES(a_no_write_in_rounds, clock, reset, cmd.round_en, !cmd.byte_we && !req_tready)

endmodule

@@ hdl/md5_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the MD5 stream hash: block buffer, bit count, chaining words,
// round unit and digest output register. Depends on md5_pkg and the assert header.
`include "md5_stream_hash_assert.svh"
module md5_dp (
   input  logic              clock,
   input  logic              reset,
   input  md5_pkg::cmd_type  cmd,
   output md5_pkg::stat_type stat,
   input  logic [7:0]        req_data,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [127:0]      rsp_tdata
);

   logic [31:0]  blk_ff [16];
   logic [63:0]  cnt_ff;
   logic [31:0]  chain_ff [4];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff;
   logic [31:0]  kw_ff, kw_in;
   logic         rsp_valid_ff;
   logic [127:0] rsp_data_ff;
   logic [7:0]   wr_byte;
   logic [31:0]  f_val;
   logic [31:0]  sum;
   logic [31:0]  rot;
   logic [4:0]   shamt;

   assign stat.fill_pos = cnt_ff[8:3];
   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;

   // Pick the byte written into the block buffer
   always_comb begin
      case (cmd.byte_sel)
         md5_pkg::BSEL_INPUT:  wr_byte = req_data;
         md5_pkg::BSEL_MARK:   wr_byte = md5_pkg::PAD_MARK_BYTE;
         md5_pkg::BSEL_LENGTH: wr_byte = cnt_ff[{cmd.byte_addr[2:0], 3'b000} +: 8];
         default:              wr_byte = 8'd0;
      endcase
   end

   // Block buffer, held as sixteen little-endian words
   always_ff @(posedge clock) begin
      if (cmd.byte_we) begin
         blk_ff[cmd.byte_addr[5:2]][{cmd.byte_addr[1:0], 3'b000} +: 8] <= wr_byte;
      end
   end

   // Round function of the current round
   always_comb begin
      case (cmd.round_idx[5:4])
         2'd0:    f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1:    f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2:    f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
   end

   // Constant plus message word one round ahead, rotate and add for this one
   assign kw_in = md5_pkg::round_const(cmd.kw_idx) + blk_ff[md5_pkg::msg_index(cmd.kw_idx)];
   assign shamt = md5_pkg::round_shift(cmd.round_idx);
   assign sum   = a_ff + f_val + kw_ff;
   assign rot   = (sum << shamt) | (sum >> (6'd32 - {1'b0, shamt}));

   // Working variables
   always_ff @(posedge clock) begin
      if (cmd.load_work) begin
         a_ff  <= chain_ff[0];
         b_ff  <= chain_ff[1];
         c_ff  <= chain_ff[2];
         d_ff  <= chain_ff[3];
         kw_ff <= kw_in;
      end else if (cmd.round_en) begin
         a_ff  <= d_ff;
         b_ff  <= b_ff + rot;
         c_ff  <= b_ff;
         d_ff  <= c_ff;
         kw_ff <= kw_in;
      end
   end

   // Chaining words and bit count; reinitialise once the digest is taken
   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         chain_ff[0] <= md5_pkg::CHAIN_INIT_A;
         chain_ff[1] <= md5_pkg::CHAIN_INIT_B;
         chain_ff[2] <= md5_pkg::CHAIN_INIT_C;
         chain_ff[3] <= md5_pkg::CHAIN_INIT_D;
         cnt_ff      <= 64'd0;
      end else begin
         if (cmd.chain_add) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
         end
         if (cmd.count_inc) begin
            cnt_ff <= cnt_ff + 64'd8;
         end
      end
   end

   // Digest output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {chain_ff[3], chain_ff[2], chain_ff[1], chain_ff[0]};
      end
   end

   `MD5_ASSERT_NEXT(a_emit_shows_digest, clock, reset, cmd.emit, rsp_tvalid)
   `MD5_ASSERT_NEXT(a_emit_clears_count, clock, reset, cmd.emit, cnt_ff == 64'd0)
   `MD5_ASSERT_NEXT(a_count_step, clock, reset, cmd.count_inc && !cmd.emit, cnt_ff == $past(cnt_ff) + 64'd8)

endmodule

@@ hdl/md5_stream_hash.sv @@
`timescale 1ns / 1ps
// MD5 stream hash, top level: controller plus datapath.
// Depends on md5_pkg, md5_ctrl and md5_dp.
//
// Usage: message bytes enter one per req_ beat. req_tdata carries the byte,
// req_tuser says the byte belongs to the message (0 for an empty beat), and
// req_tlast closes the message. A closing beat with req_tuser low ends the
// message without adding a byte, so an empty message can be hashed.
// When a beat fills the 64-byte block, the compression of that block
// (load, 64 rounds, one add) runs on the single shared round unit, and
// req_tready is low throughout, so no byte is taken until it is done.
// After a closing beat, padding writes one byte per cycle and runs one or
// two compressions before the digest appears on rsp_tdata (word A in the
// lowest 32 bits). The digest sits in an output register, so the next
// message may start while rsp_tready is low; only a second digest waits
// for the first to be taken.
// Reset clears the chaining words, bit count and handshakes; no clearing
// pass is needed.
module md5_stream_hash (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tuser,   // [0] byte_valid
   input  logic         req_tlast,   // end of message
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // digest_a, digest_b, digest_c, digest_d
);

   md5_pkg::cmd_type  cmd;
   md5_pkg::stat_type stat;

   md5_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_byte_valid (req_tuser),
      .req_last       (req_tlast),
      .stat           (stat),
      .cmd            (cmd)
   );

   md5_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_data   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
